// ===== design/sensor_template_nearest_match_macros.svh =====
// Assertion macros used by the checker file.
`ifndef SENSOR_TEMPLATE_NEAREST_MATCH_MACROS_SVH
`define SENSOR_TEMPLATE_NEAREST_MATCH_MACROS_SVH

// Checks that a condition implies a consequence in the same cycle.
`define STNM_ASSERT_IMPL(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Checks that a condition implies a consequence in the next cycle.
`define STNM_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/stnm_pkg.sv =====
package stnm_pkg;
    localparam int unsigned CHANNELS  = 4;
    localparam int unsigned OP_BITS   = 3;
    localparam int unsigned SLOT_BITS = 5;
    localparam int unsigned TAG_BITS  = 16;
    localparam int unsigned DIST_BITS = 11;

    typedef enum logic [OP_BITS-1:0] {
        OP_STORE          = 3'd0,
        OP_CLASSIFY       = 3'd1,
        OP_PEAK_START     = 3'd2,
        OP_PEAK_SAMPLE    = 3'd3,
        OP_STORE_PEAKS    = 3'd4,
        OP_CLASSIFY_PEAKS = 3'd5
    } t_op;
endpackage

// ===== design/stnm_if.sv =====
interface stnm_in_if #(parameter int SAMPLE_BITS = 10);
    logic                    valid;
    logic                    ready;
    logic [2:0]              operation;
    logic [SAMPLE_BITS-1:0]  chan_a;
    logic [SAMPLE_BITS-1:0]  chan_b;
    logic [SAMPLE_BITS-1:0]  chan_c;
    logic [SAMPLE_BITS-1:0]  chan_d;
    logic [4:0]              slot;
    logic [15:0]             tag;
    modport source (output valid, operation, chan_a, chan_b, chan_c, chan_d, slot, tag,
                    input ready);
    modport sink   (input valid, operation, chan_a, chan_b, chan_c, chan_d, slot, tag,
                    output ready);
endinterface

interface stnm_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] match_tag;
    logic [4:0]  match_slot;
    logic [10:0] match_distance;
    modport source (output valid, match_tag, match_slot, match_distance, input ready);
    modport sink   (input valid, match_tag, match_slot, match_distance, output ready);
endinterface

// ===== design/sensor_template_nearest_match.sv =====
// Channel  Dir  Payload
// in       in   operation, chan_a..chan_d, slot, tag
// out      out  match_tag, match_slot, match_distance
// Stores and peak operations leave the input ready.
// A classify walks the query along the chain of TABLE_ENTRIES cells to find the
// smallest square sum, takes its floor root, then walks again to find the lowest
// entry whose sum floors to that root. A synchronous reset clears the table and peaks together.
// A result held by a stalled sink blocks new items until it is taken; the input
// is ready the cycle after.
module sensor_template_nearest_match import stnm_pkg::*; #(
    parameter int TABLE_ENTRIES = 20,
    parameter int SAMPLE_BITS   = 10
) (
    input  logic i_clk,
    input  logic i_rst_n,
    stnm_in_if.sink    in_ch,
    stnm_out_if.source out_ch
);
    localparam int SW      = CHANNELS * SAMPLE_BITS;
    localparam int SQ_BITS = 2 * SAMPLE_BITS + 2;
    localparam int RW      = SQ_BITS / 2;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_WALK = 6'b000010,
        S_ROOT = 6'b000100,
        S_LOAD = 6'b001000,
        S_SCAN = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [SW-1:0]  r_peak;
    logic [SW-1:0]  n_sample;
    logic [SW-1:0]  n_peak;
    logic [SW-1:0]  n_query;
    logic [SW-1:0]  r_query;
    logic           acc;
    logic           is_cls;
    logic           do_store;
    logic           scan;
    logic [TABLE_ENTRIES:0]      v_ch;
    logic [SW-1:0]               q_ch [TABLE_ENTRIES+1];
    logic [SQ_BITS-1:0]          b_ch [TABLE_ENTRIES+1];
    logic [SLOT_BITS-1:0]        s_ch [TABLE_ENTRIES+1];
    logic [TAG_BITS-1:0]         t_ch [TABLE_ENTRIES+1];
    logic [SLOT_BITS-1:0]        r_slot;
    logic [TAG_BITS-1:0]         r_tag;
    logic                        root_busy, root_done;
    logic [RW-1:0]               root;
    logic [RW:0]                 root_p1;
    logic [SQ_BITS-1:0]          n_thresh;
    logic [SQ_BITS-1:0]          r_thresh;
    logic [DIST_BITS-1:0]        r_dist;

    assign n_sample = {in_ch.chan_d, in_ch.chan_c, in_ch.chan_b, in_ch.chan_a};
    assign in_ch.ready = (r_state == S_IDLE);
    assign acc = in_ch.valid && in_ch.ready;
    assign is_cls = (in_ch.operation == OP_CLASSIFY) ||
                    (in_ch.operation == OP_CLASSIFY_PEAKS);
    assign do_store = acc && ((in_ch.operation == OP_STORE) ||
                              (in_ch.operation == OP_STORE_PEAKS));
    assign n_query = (in_ch.operation == OP_CLASSIFY_PEAKS) ? r_peak : n_sample;
    assign scan = (r_state inside {S_LOAD, S_SCAN});

    // A sum no smaller than r squared floors to a root r exactly when it is below (r + 1) squared.
    assign root_p1  = {1'b0, root} + (RW+1)'(1);
    assign n_thresh = SQ_BITS'(root_p1 * root_p1);

    always_comb begin
        n_peak = r_peak;
        for (int c = 0; c < CHANNELS; c++) begin
            if (in_ch.operation == OP_PEAK_START ||
                n_sample[c*SAMPLE_BITS +: SAMPLE_BITS] >
                r_peak[c*SAMPLE_BITS +: SAMPLE_BITS])
                n_peak[c*SAMPLE_BITS +: SAMPLE_BITS] =
                    n_sample[c*SAMPLE_BITS +: SAMPLE_BITS];
        end
    end

    assign v_ch[0] = (acc && is_cls) || (r_state == S_LOAD);
    assign q_ch[0] = scan ? r_query : n_query;
    assign b_ch[0] = scan ? r_thresh : '0;
    assign s_ch[0] = '0;
    assign t_ch[0] = '0;

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        stnm_cell #(
            .SAMPLE_BITS(SAMPLE_BITS),
            .SQ_BITS(SQ_BITS),
            .INDEX(SLOT_BITS'(g))
        ) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_wr(do_store && (in_ch.slot == SLOT_BITS'(g))),
            .i_wr_vec((in_ch.operation == OP_STORE_PEAKS) ? r_peak : n_sample),
            .i_wr_tag(in_ch.tag),
            .i_valid(v_ch[g]), .i_scan(scan), .i_query(q_ch[g]), .i_first(g == 0),
            .i_best(b_ch[g]), .i_slot(s_ch[g]), .i_tag(t_ch[g]),
            .o_valid(v_ch[g+1]), .o_query(q_ch[g+1]), .o_best(b_ch[g+1]),
            .o_slot(s_ch[g+1]), .o_tag(t_ch[g+1])
        );
    end

    stnm_root #(.SQ_BITS(SQ_BITS)) u_root (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(v_ch[TABLE_ENTRIES] && (r_state == S_WALK)),
        .i_value(b_ch[TABLE_ENTRIES]),
        .o_busy(root_busy), .o_done(root_done), .o_root(root)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (acc && is_cls) n_state = S_WALK;
            S_WALK: if (v_ch[TABLE_ENTRIES]) n_state = S_ROOT;
            S_ROOT: if (root_done) n_state = S_LOAD;
            S_LOAD: n_state = S_SCAN;
            S_SCAN: if (v_ch[TABLE_ENTRIES]) n_state = S_OUT;
            S_OUT:  if (out_ch.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_peak  <= '0;
        end else begin
            r_state <= n_state;
            if (acc && (in_ch.operation == OP_PEAK_START ||
                        in_ch.operation == OP_PEAK_SAMPLE))
                r_peak <= n_peak;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && is_cls)
            r_query <= n_query;
        if (v_ch[TABLE_ENTRIES] && (r_state == S_SCAN)) begin
            r_slot <= s_ch[TABLE_ENTRIES];
            r_tag  <= t_ch[TABLE_ENTRIES];
        end
        if (root_done && !root_busy) begin
            r_dist   <= DIST_BITS'(root);
            r_thresh <= n_thresh;
        end
    end

    assign out_ch.valid          = (r_state == S_OUT);
    assign out_ch.match_tag      = r_tag;
    assign out_ch.match_slot     = r_slot;
    assign out_ch.match_distance = r_dist;
endmodule

// ===== design/stnm_cell.sv =====
// One table entry. Holds a template and its label; in each cycle it takes the
// query and the running best from the left neighbor, compares its own square
// sum and hands the updated best to the right.
module stnm_cell import stnm_pkg::*; #(
    parameter int SAMPLE_BITS = 10,
    parameter int SQ_BITS     = 2 * SAMPLE_BITS + 2,
    parameter logic [SLOT_BITS-1:0] INDEX = '0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr,
    input  logic [CHANNELS*SAMPLE_BITS-1:0] i_wr_vec,
    input  logic [TAG_BITS-1:0]           i_wr_tag,
    input  logic                          i_valid,
    input  logic                          i_scan,
    input  logic [CHANNELS*SAMPLE_BITS-1:0] i_query,
    input  logic                          i_first,
    input  logic [SQ_BITS-1:0]            i_best,
    input  logic [SLOT_BITS-1:0]          i_slot,
    input  logic [TAG_BITS-1:0]           i_tag,
    output logic                          o_valid,
    output logic [CHANNELS*SAMPLE_BITS-1:0] o_query,
    output logic [SQ_BITS-1:0]            o_best,
    output logic [SLOT_BITS-1:0]          o_slot,
    output logic [TAG_BITS-1:0]           o_tag
);
    logic [CHANNELS*SAMPLE_BITS-1:0] r_vec;
    logic [TAG_BITS-1:0]             r_tag;
    logic                            r_valid;
    logic [CHANNELS*SAMPLE_BITS-1:0] r_query;
    logic [SQ_BITS-1:0]              r_best;
    logic [SLOT_BITS-1:0]            r_slot;
    logic [TAG_BITS-1:0]             r_otag;
    logic [SQ_BITS-1:0]              n_sum;
    logic                            n_take;

    // In the first pass the running best is the smallest square sum so far.
    // In the second pass it starts as the bound below which a sum floors to
    // the winning root; the first cell under it takes the match and passes on
    // zero so that no later cell can take it again.
    always_comb begin
        logic [SAMPLE_BITS-1:0] a, b, d;
        n_sum = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            a = i_query[c*SAMPLE_BITS +: SAMPLE_BITS];
            b = r_vec[c*SAMPLE_BITS +: SAMPLE_BITS];
            d = (a > b) ? a - b : b - a;
            n_sum = n_sum + SQ_BITS'(d * d);
        end
        n_take = (i_first && !i_scan) || (n_sum < i_best);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vec   <= '0;
            r_tag   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_wr) begin
                r_vec <= i_wr_vec;
                r_tag <= i_wr_tag;
            end
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_query <= i_query;
        r_best  <= n_take ? (i_scan ? '0 : n_sum) : i_best;
        r_slot  <= n_take ? INDEX : i_slot;
        r_otag  <= n_take ? r_tag : i_tag;
    end

    assign o_valid = r_valid;
    assign o_query = r_query;
    assign o_best  = r_best;
    assign o_slot  = r_slot;
    assign o_tag   = r_otag;
endmodule

// ===== design/stnm_root.sv =====
// Bit-serial floor square root: two radicand bits per result bit; a start while busy restarts it.
module stnm_root #(
    parameter int SQ_BITS = 22,
    parameter int RW      = SQ_BITS / 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [SQ_BITS-1:0] i_value,
    output logic               o_busy,
    output logic               o_done,
    output logic [RW-1:0]      o_root
);
    localparam int CW = $clog2(RW + 1);
    logic [SQ_BITS-1:0] r_rem;
    logic [SQ_BITS-1:0] r_res;
    logic [SQ_BITS-1:0] r_bit;
    logic [CW-1:0]      r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [SQ_BITS-1:0] n_trial;

    assign n_trial = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(RW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_value;
            r_res <= '0;
            r_bit <= SQ_BITS'(1) << (2 * (RW - 1));
        end else if (r_busy) begin
            if (r_rem >= n_trial) begin
                r_rem <= r_rem - n_trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_root = r_res[RW-1:0];
endmodule

// ===== design/stnm_checker.sv =====
`include "sensor_template_nearest_match_macros.svh"
module stnm_checker import stnm_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [2:0]  in_op,
    input logic        out_valid,
    input logic        out_ready,
    input logic [4:0]  out_slot
);
    `STNM_ASSERT_IMPL(a_no_in_while_out, i_clk, i_rst_n, out_valid, !in_ready, "input taken while result pending")
    `STNM_ASSERT_NEXT(a_hold, i_clk, i_rst_n, out_valid && !out_ready, out_valid && $stable(out_slot), "result dropped")
    `STNM_ASSERT_NEXT(a_cls_busy, i_clk, i_rst_n, in_valid && in_ready && (in_op == OP_CLASSIFY || in_op == OP_CLASSIFY_PEAKS), !in_ready, "classify did not block")
    `STNM_ASSERT_NEXT(a_store_quiet, i_clk, i_rst_n, in_valid && in_ready && in_op == OP_STORE, !out_valid, "store gave result")
endmodule

bind sensor_template_nearest_match stnm_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_op(in_ch.operation),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_slot(out_ch.match_slot)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import stnm_pkg::*;

    localparam int ENTRIES  = 20;
    localparam int SBITS    = 10;
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    typedef logic [SBITS-1:0] t_sample;

    typedef struct packed {
        logic [2:0]  operation;
        t_sample     chan_a;
        t_sample     chan_b;
        t_sample     chan_c;
        t_sample     chan_d;
        logic [4:0]  slot;
        logic [15:0] tag;
    } t_request;

    typedef struct packed {
        logic [15:0] match_tag;
        logic [4:0]  match_slot;
        logic [10:0] match_distance;
    } t_match;

    logic i_clk;
    logic i_rst_n;

    stnm_in_if #(.SAMPLE_BITS(SBITS)) in_ch();
    stnm_out_if out_ch();

    sensor_template_nearest_match #(
        .TABLE_ENTRIES(ENTRIES),
        .SAMPLE_BITS(SBITS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch)
    );

    // Shadow copy of the template table and the peak-hold register.
    t_sample     shadow_tmpl[ENTRIES][4];
    logic [15:0] shadow_tag[ENTRIES];
    t_sample     shadow_peak[4];

    t_request pending_requests[$];
    t_match   expected_matches[$];
    t_request sent_request;
    int send_idle_pct;
    int recv_idle_pct;
    int error_count;
    int classify_count;
    int transfer_count;
    int match_count;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic logic [11:0] floor_sqrt(input logic [23:0] value);
        logic [23:0] rem;
        logic [23:0] root;
        logic [23:0] bitpos;
        rem = value;
        root = '0;
        bitpos = 24'h400000;
        while (bitpos > rem) bitpos = bitpos >> 2;
        while (bitpos != 0) begin
            if (rem >= root + bitpos) begin
                rem = rem - (root + bitpos);
                root = (root >> 1) + bitpos;
            end else begin
                root = root >> 1;
            end
            bitpos = bitpos >> 2;
        end
        return root[11:0];
    endfunction

    function automatic t_match nearest_template(input t_sample query[4]);
        t_match best;
        logic [23:0] sum;
        logic [11:0] near_dist;
        logic [11:0] best_dist;
        int diff;
        best = '0;
        best_dist = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            sum = '0;
            for (int c = 0; c < 4; c++) begin
                diff = int'(query[c]) - int'(shadow_tmpl[i][c]);
                sum = sum + 24'(diff * diff);
            end
            near_dist = floor_sqrt(sum);
            // Only a strictly smaller floored distance wins, so ties keep the lower index.
            if (i == 0 || near_dist < best_dist) begin
                best_dist = near_dist;
                best.match_slot = i[4:0];
            end
        end
        best.match_tag = shadow_tag[best.match_slot];
        best.match_distance = best_dist[10:0];
        return best;
    endfunction

    task automatic apply_request(input t_request req);
        t_sample vec[4];
        vec[0] = req.chan_a;
        vec[1] = req.chan_b;
        vec[2] = req.chan_c;
        vec[3] = req.chan_d;
        case (req.operation)
            OP_STORE, OP_STORE_PEAKS: begin
                if (req.slot < ENTRIES) begin
                    for (int c = 0; c < 4; c++)
                        shadow_tmpl[req.slot][c] = (req.operation == OP_STORE) ?
                                                   vec[c] : shadow_peak[c];
                    shadow_tag[req.slot] = req.tag;
                end
            end
            OP_CLASSIFY: begin
                expected_matches.push_back(nearest_template(vec));
                classify_count++;
            end
            OP_PEAK_START: begin
                for (int c = 0; c < 4; c++) shadow_peak[c] = vec[c];
            end
            OP_PEAK_SAMPLE: begin
                for (int c = 0; c < 4; c++)
                    if (vec[c] > shadow_peak[c]) shadow_peak[c] = vec[c];
            end
            OP_CLASSIFY_PEAKS: begin
                expected_matches.push_back(nearest_template(shadow_peak));
                classify_count++;
            end
            default: begin
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // Sender side: a new request goes out once the previous one has been transferred.
    logic in_taken;
    always @(posedge i_clk) begin
        in_taken = i_rst_n && in_ch.valid && in_ch.ready;
        if (in_taken) begin
            apply_request(sent_request);
            transfer_count++;
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && (!in_ch.valid || in_taken)) begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                sent_request = pending_requests.pop_front();
                in_ch.operation <= sent_request.operation;
                in_ch.chan_a <= sent_request.chan_a;
                in_ch.chan_b <= sent_request.chan_b;
                in_ch.chan_c <= sent_request.chan_c;
                in_ch.chan_d <= sent_request.chan_d;
                in_ch.slot <= sent_request.slot;
                in_ch.tag <= sent_request.tag;
                in_ch.valid <= 1'b1;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
        if (i_rst_n) out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Receiver side: compare every transferred result with the oldest prediction.
    always @(posedge i_clk) begin
        t_match want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            match_count++;
            if (expected_matches.size() == 0) begin
                $display("[%0t] unexpected result transfer", $realtime);
                error_count++;
            end else begin
                want = expected_matches.pop_front();
                if (out_ch.match_tag !== want.match_tag)
                    report_mismatch("match_tag", out_ch.match_tag, want.match_tag);
                if (out_ch.match_slot !== want.match_slot)
                    report_mismatch("match_slot", out_ch.match_slot, want.match_slot);
                if (out_ch.match_distance !== want.match_distance)
                    report_mismatch("match_distance", out_ch.match_distance,
                                    want.match_distance);
            end
        end
    end

    function automatic t_request make_request(input logic [2:0] op, input int a, input int b,
                                              input int c, input int d, input int slot,
                                              input int tag);
        t_request req;
        req.operation = op;
        req.chan_a = t_sample'(a);
        req.chan_b = t_sample'(b);
        req.chan_c = t_sample'(c);
        req.chan_d = t_sample'(d);
        req.slot = 5'(slot);
        req.tag = 16'(tag);
        return req;
    endfunction

    // Values mostly cluster around a few centers so that near ties are common.
    function automatic int pick_channel(input int center);
        case ($urandom_range(9))
            0: return $urandom_range(1023);
            1: return ($urandom_range(1)) ? 1023 : 0;
            default: begin
                int v;
                v = center + $urandom_range(8) - 4;
                return (v < 0) ? 0 : ((v > 1023) ? 1023 : v);
            end
        endcase
    endfunction

    function automatic t_request random_request();
        int center;
        int roll;
        int slot;
        logic [2:0] op;
        center = $urandom_range(3) * 300 + $urandom_range(20);
        roll = $urandom_range(99);
        if (roll < 25) op = OP_STORE;
        else if (roll < 55) op = OP_CLASSIFY;
        else if (roll < 65) op = OP_PEAK_START;
        else if (roll < 78) op = OP_PEAK_SAMPLE;
        else if (roll < 87) op = OP_STORE_PEAKS;
        else if (roll < 96) op = OP_CLASSIFY_PEAKS;
        else op = ($urandom_range(1)) ? OP_SPARE_LO : OP_SPARE_HI;
        slot = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(ENTRIES - 1);
        return make_request(op, pick_channel(center), pick_channel(center),
                            pick_channel(center), pick_channel(center), slot,
                            $urandom_range(65535));
    endfunction

    task automatic drain();
        while (pending_requests.size() > 0 || in_ch.valid || expected_matches.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        error_count = 0;
        classify_count = 0;
        transfer_count = 0;
        match_count = 0;
        send_idle_pct = 31;
        recv_idle_pct = 53;
        in_taken = 1'b0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.operation = OP_STORE;
        in_ch.chan_a = '0;
        in_ch.chan_b = '0;
        in_ch.chan_c = '0;
        in_ch.chan_d = '0;
        in_ch.slot = '0;
        in_ch.tag = '0;
        out_ch.ready = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
            shadow_tag[i] = '0;
            for (int c = 0; c < 4; c++) shadow_tmpl[i][c] = '0;
        end
        for (int c = 0; c < 4; c++) shadow_peak[c] = '0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: extremes, every operation, ignored slots, spare codes.
        pending_requests.push_back(make_request(OP_CLASSIFY, 0, 0, 0, 0, 0, 0));
        pending_requests.push_back(make_request(OP_PEAK_SAMPLE, 7, 1023, 0, 512, 0, 0));
        pending_requests.push_back(make_request(OP_CLASSIFY_PEAKS, 0, 0, 0, 0, 0, 0));
        pending_requests.push_back(make_request(OP_STORE, 1023, 1023, 1023, 1023, 19, 65535));
        pending_requests.push_back(make_request(OP_CLASSIFY, 1023, 1023, 1023, 1023, 0, 0));
        pending_requests.push_back(make_request(OP_STORE, 1, 2, 3, 4, 20, 111));
        pending_requests.push_back(make_request(OP_STORE_PEAKS, 0, 0, 0, 0, 31, 222));
        pending_requests.push_back(make_request(OP_CLASSIFY, 1, 2, 3, 4, 0, 0));
        // Same floored distance, larger square sum at the lower index.
        pending_requests.push_back(make_request(OP_STORE, 100, 3, 1, 0, 3, 16'h5555));
        pending_requests.push_back(make_request(OP_STORE, 103, 0, 0, 0, 4, 16'haaaa));
        pending_requests.push_back(make_request(OP_CLASSIFY, 100, 0, 0, 0, 0, 0));
        pending_requests.push_back(make_request(OP_PEAK_START, 1023, 0, 0, 0, 0, 0));
        pending_requests.push_back(make_request(OP_PEAK_SAMPLE, 5, 1023, 1023, 0, 0, 0));
        pending_requests.push_back(make_request(OP_STORE_PEAKS, 0, 0, 0, 0, 0, 16'h1234));
        pending_requests.push_back(make_request(OP_CLASSIFY_PEAKS, 0, 0, 0, 0, 0, 0));
        pending_requests.push_back(make_request(OP_SPARE_LO, 1023, 1023, 1023, 1023, 2, 9));
        pending_requests.push_back(make_request(OP_SPARE_HI, 1023, 1023, 1023, 1023, 3, 9));
        pending_requests.push_back(make_request(OP_CLASSIFY, 0, 1023, 0, 1023, 0, 0));
        pending_requests.push_back(make_request(OP_CLASSIFY, 1023, 0, 0, 0, 0, 0));
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 31 : ((phase == 1) ? 53 : 0);
            recv_idle_pct = (phase == 0) ? 53 : ((phase == 1) ? 31 : 0);
            for (int n = 0; n < 350; n++) pending_requests.push_back(random_request());
            drain();
        end

        repeat (60) @(posedge i_clk);
        $display("covered %0d request transfers, %0d classifications, %0d results checked",
                 transfer_count, classify_count, match_count);
        $display("three idle mixes, stores to ignored slots, spare codes and distance ties");
        if (error_count == 0 && expected_matches.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
